/* design/dual_steering_sensor_plausibility_assert.svh */
// Assertion macros shared by the checker of the steering sensor plausibility block.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef DUAL_STEERING_SENSOR_PLAUSIBILITY_ASSERT_SVH
`define DUAL_STEERING_SENSOR_PLAUSIBILITY_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSSP_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DSSP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/dssp_pkg.sv */
// Package of the steering sensor plausibility block: field widths, register
// indexes, configuration and control structs and state encodings. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dssp_pkg;

  localparam int unsigned READ_W     = 16;
  localparam int unsigned ANGLE_W    = 14;
  localparam int unsigned OFFS_W     = 13;
  localparam int unsigned LIMIT_W    = 13;
  localparam int unsigned TMO_W      = 8;
  localparam int unsigned SEND_W     = 4;
  localparam int unsigned COUNT_W    = 9;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 72;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Bit positions inside the output tdata.
  localparam int unsigned OUT_ANGLE_A_LSB = 0;
  localparam int unsigned OUT_ANGLE_B_LSB = 14;
  localparam int unsigned OUT_DISC_A_BIT  = 28;
  localparam int unsigned OUT_DISC_B_BIT  = 29;
  localparam int unsigned OUT_IMP_BIT     = 30;
  localparam int unsigned OUT_WARN_BIT    = 31;
  localparam int unsigned OUT_DIS_BIT     = 32;
  localparam int unsigned OUT_SEND_BIT    = 33;
  localparam int unsigned OUT_RAW_A_LSB   = 34;
  localparam int unsigned OUT_RAW_B_LSB   = 50;
  localparam int unsigned OUT_USED_W      = 66;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_MIN     = 3'd0,
    REG_MAP_MAX     = 3'd1,
    REG_OFFSET_A    = 3'd2,
    REG_OFFSET_B    = 3'd3,
    REG_MAX_DIFF    = 3'd4,
    REG_DISC_CUTOFF = 3'd5,
    REG_TIMEOUT     = 3'd6,
    REG_SEND_IVL    = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [READ_W-1:0]         map_min;
    logic [READ_W-1:0]         map_max;
    logic signed [OFFS_W-1:0]  offset_a;
    logic signed [OFFS_W-1:0]  offset_b;
    logic [LIMIT_W-1:0]        max_diff;
    logic [READ_W-1:0]         disc_cutoff;
    logic [TMO_W-1:0]          timeout;
    logic [SEND_W-1:0]         send_ivl;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    map_min:     16'd0,
    map_max:     16'd65535,
    offset_a:    13'sd0,
    offset_b:    13'sd0,
    max_diff:    13'd100,
    disc_cutoff: 16'd0,
    timeout:     8'd10,
    send_ivl:    4'd5
  };

  // Sequencer outputs toward the datapath.
  typedef struct packed {
    logic in_ready;
    logic start_map;
    logic sel_b;
    logic cap_a;
    logic cap_b;
    logic commit;
  } ctrl_t;

  // Result flags and angles, packed in the order they sit in the output tdata.
  typedef struct packed {
    logic               send;
    logic               dis;
    logic               warn;
    logic               imp;
    logic               disc_b;
    logic               disc_a;
    logic [ANGLE_W-1:0] angle_b;
    logic [ANGLE_W-1:0] angle_a;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAP_A,
    ST_MAP_B,
    ST_EVAL
  } ctrl_state_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MUL,
    PH_DIV,
    PH_DONE
  } map_phase_e;

endpackage

`default_nettype wire

/* design/dssp_map_unit.sv */
// Shared mapping unit: clamps one reading, scales it by the angle span and divides
// by the map range with a restoring divider, one quotient bit per cycle. Uses dssp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dssp_map_unit #(
  parameter int unsigned SPAN = 3600,
  localparam int unsigned QW = $clog2(SPAN + 1)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [dssp_pkg::READ_W-1:0] reading_i,
  input  wire logic [dssp_pkg::READ_W-1:0] map_min_i,
  input  wire logic [dssp_pkg::READ_W-1:0] map_max_i,
  output logic                             done_o,
  output logic [QW-1:0]                    mapped_o
);

  localparam int unsigned RW = dssp_pkg::READ_W;
  localparam int unsigned CW = $clog2(QW);
  localparam int unsigned PW = RW + QW;
  localparam logic [QW-1:0] SPAN_C = QW'(SPAN);

  dssp_pkg::map_phase_e phase_q, phase_d;
  logic [CW-1:0] cnt_q;
  logic          load, mul_en, div_en;

  logic [RW-1:0] clamped, ofs_q, den_q, rem_q, rem_d;
  logic          empty_q;
  logic [QW-1:0] low_q, quo_q;
  logic [PW-1:0] prod;
  logic [RW:0]   trial;
  logic          fits;

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      dssp_pkg::PH_IDLE: if (start_i) phase_d = dssp_pkg::PH_MUL;
      dssp_pkg::PH_MUL:  phase_d = dssp_pkg::PH_DIV;
      dssp_pkg::PH_DIV:  if (cnt_q == '0) phase_d = dssp_pkg::PH_DONE;
      dssp_pkg::PH_DONE: phase_d = start_i ? dssp_pkg::PH_MUL : dssp_pkg::PH_IDLE;
      default:           phase_d = dssp_pkg::PH_IDLE;
    endcase
  end

  // Phase decode.
  always_comb begin
    load   = 1'b0;
    mul_en = 1'b0;
    div_en = 1'b0;
    done_o = 1'b0;
    case (phase_q)
      dssp_pkg::PH_IDLE: load = start_i;
      dssp_pkg::PH_MUL:  mul_en = 1'b1;
      dssp_pkg::PH_DIV:  div_en = 1'b1;
      dssp_pkg::PH_DONE: begin
        done_o = 1'b1;
        load   = start_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dssp_pkg::PH_IDLE;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      if (mul_en) begin
        cnt_q <= CW'(QW - 1);
      end else if (div_en) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_comb begin
    if (reading_i < map_min_i) begin
      clamped = map_min_i;
    end else if (reading_i > map_max_i) begin
      clamped = map_max_i;
    end else begin
      clamped = reading_i;
    end
  end

  assign prod  = PW'(ofs_q) * PW'(SPAN_C);
  assign trial = {rem_q, low_q[QW-1]} - {1'b0, den_q};
  assign fits  = !trial[RW];
  // The partial remainder stays below the divisor, so it never needs more than RW bits.
  assign rem_d = fits ? trial[RW-1:0] : {rem_q[RW-2:0], low_q[QW-1]};

  always_ff @(posedge clk_i) begin
    if (load) begin
      ofs_q   <= clamped - map_min_i;
      den_q   <= map_max_i - map_min_i;
      empty_q <= (map_max_i <= map_min_i);
    end
    if (mul_en) begin
      // The quotient fits QW bits, so the upper product bits start out below the divisor.
      rem_q <= prod[PW-1:QW];
      low_q <= prod[QW-1:0];
    end else if (div_en) begin
      rem_q <= rem_d;
      low_q <= {low_q[QW-2:0], 1'b0};
      quo_q <= {quo_q[QW-2:0], fits};
    end
  end

  assign mapped_o = empty_q ? '0 : quo_q;

endmodule

`default_nettype wire

/* design/dssp_ctrl.sv */
// Sequencer of the plausibility block: takes a sample, runs the mapping unit on
// channel A and then B, and commits the result. Uses dssp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dssp_ctrl (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     map_done_i,
  input  wire logic     out_free_i,
  output dssp_pkg::ctrl_t ctl_o
);

  dssp_pkg::ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      dssp_pkg::ST_IDLE:  if (in_valid_i) state_d = dssp_pkg::ST_MAP_A;
      dssp_pkg::ST_MAP_A: if (map_done_i) state_d = dssp_pkg::ST_MAP_B;
      dssp_pkg::ST_MAP_B: if (map_done_i) state_d = dssp_pkg::ST_EVAL;
      dssp_pkg::ST_EVAL:  if (out_free_i) state_d = dssp_pkg::ST_IDLE;
      default:            state_d = dssp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o = '0;
    case (state_q)
      dssp_pkg::ST_IDLE: begin
        ctl_o.in_ready  = 1'b1;
        ctl_o.start_map = in_valid_i;
      end
      dssp_pkg::ST_MAP_A: begin
        // Channel B starts in the same cycle that channel A is captured.
        ctl_o.cap_a     = map_done_i;
        ctl_o.start_map = map_done_i;
        ctl_o.sel_b     = 1'b1;
      end
      dssp_pkg::ST_MAP_B: ctl_o.cap_b = map_done_i;
      dssp_pkg::ST_EVAL:  ctl_o.commit = out_free_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dssp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* design/dssp_monitor.sv */
// Plausibility monitor: compares the two angles, checks for disconnects, and keeps
// the implausible run count, warning, disable latch and send counter. Uses dssp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dssp_monitor #(
  parameter int unsigned AW = 14
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        commit_i,
  input  wire dssp_pkg::cfg_t              cfg_i,
  input  wire logic [dssp_pkg::READ_W-1:0] reading_a_i,
  input  wire logic [dssp_pkg::READ_W-1:0] reading_b_i,
  input  wire logic signed [AW-1:0]        ang_a_i,
  input  wire logic signed [AW-1:0]        ang_b_i,
  output dssp_pkg::res_t                   res_o
);

  localparam int unsigned CNW = dssp_pkg::COUNT_W;
  localparam int unsigned SW  = dssp_pkg::SEND_W;

  logic [CNW-1:0] cnt_q, cnt_d;
  logic           run_q, run_d;
  logic           warn_q, warn_d;
  logic           latch_q, latch_d;
  logic [SW-1:0]  send_q, send_d, send_inc;
  logic           send;

  logic [AW:0] diff, mag;
  logic        disc_a, disc_b, imp;

  assign diff   = {ang_a_i[AW-1], ang_a_i} - {ang_b_i[AW-1], ang_b_i};
  assign mag    = diff[AW] ? (~diff + 1'b1) : diff;
  assign disc_a = reading_a_i < cfg_i.disc_cutoff;
  assign disc_b = reading_b_i < cfg_i.disc_cutoff;
  assign imp    = disc_a || disc_b || (mag > (AW + 1)'(cfg_i.max_diff));

  always_comb begin
    cnt_d   = cnt_q;
    run_d   = run_q;
    warn_d  = warn_q;
    latch_d = latch_q;
    if (imp) begin
      run_d = 1'b1;
      // The first implausible period of a run starts the count at zero.
      if (!run_q) begin
        cnt_d = '0;
      end else if (cnt_q != dssp_pkg::COUNT_MAX) begin
        cnt_d = cnt_q + 1'b1;
      end
      if (cnt_d > CNW'(cfg_i.timeout)) begin
        warn_d  = 1'b1;
        latch_d = 1'b1;
      end
    end else begin
      run_d  = 1'b0;
      cnt_d  = '0;
      warn_d = 1'b0;
    end
  end

  assign send_inc = send_q + 1'b1;
  assign send     = send_inc >= cfg_i.send_ivl;
  assign send_d   = send ? '0 : send_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      run_q   <= 1'b0;
      warn_q  <= 1'b0;
      latch_q <= 1'b0;
      send_q  <= '0;
    end else if (commit_i) begin
      cnt_q   <= cnt_d;
      run_q   <= run_d;
      warn_q  <= warn_d;
      latch_q <= latch_d;
      send_q  <= send_d;
    end
  end

  always_comb begin
    res_o.angle_a = ang_a_i[dssp_pkg::ANGLE_W-1:0];
    res_o.angle_b = ang_b_i[dssp_pkg::ANGLE_W-1:0];
    res_o.disc_a  = disc_a;
    res_o.disc_b  = disc_b;
    res_o.imp     = imp;
    res_o.warn    = warn_d;
    res_o.dis     = latch_d;
    res_o.send    = send;
  end

endmodule

`default_nettype wire

/* design/dual_steering_sensor_plausibility.sv */
// Top level of the dual steering sensor plausibility checker: configuration
// registers, sample and output registers. Uses dssp_pkg, dssp_ctrl, dssp_map_unit, dssp_monitor.
//
//   channel  direction  handshake                      payload
//   s_axis   in         s_axis_tvalid / s_axis_tready  s_axis_tdata, 64 bits
//   m_axis   out        m_axis_tvalid / m_axis_tready  m_axis_tdata, 72 bits
//   cfg      in         cfg_wr_en_i                    cfg_addr_i, cfg_wdata_i
//
// A new sample is taken only once the last one has been mapped and committed. The shared
// restoring divider maps channel A and then channel B at one quotient bit per cycle, each
// after its own multiply step.
// The result register holds a finished report while the next sample is mapped;
// the sequencer waits in its commit step only if that register is still full.
// Reset clears control state and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module dual_steering_sensor_plausibility #(
  parameter int unsigned READING_BITS      = 16,
  parameter int unsigned ANGLE_SPAN_TENTHS = 3600
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // reading_a, reading_b, raw_a, raw_b (16 bits each)
  input  wire logic [dssp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // angle_a, angle_b (14 each), disconnected_a, disconnected_b, implausible_now,
  // implausible_warning, disable_vectoring, send_now, raw_a_out, raw_b_out (16 each)
  output logic [dssp_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  input  wire logic                            cfg_wr_en_i,
  input  wire logic [dssp_pkg::CFG_IDX_W-1:0]  cfg_addr_i,
  input  wire logic [dssp_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned RW = dssp_pkg::READ_W;
  localparam int unsigned OW = dssp_pkg::OFFS_W;
  localparam int unsigned QW = $clog2(ANGLE_SPAN_TENTHS + 1);
  localparam int unsigned AW = (QW + 2 > dssp_pkg::ANGLE_W) ? QW + 2 : dssp_pkg::ANGLE_W;
  localparam int unsigned RB_EFF = (READING_BITS < RW) ? READING_BITS : RW;
  localparam logic [RW-1:0] READ_MASK = RW'((64'd1 << RB_EFF) - 64'd1);

  dssp_pkg::cfg_t  cfg_q;
  dssp_pkg::ctrl_t ctl;
  dssp_pkg::res_t  res;
  dssp_pkg::res_t  out_res_q;

  logic [RW-1:0]        ra_q, rb_q, raw_a_q, raw_b_q, out_raw_a_q, out_raw_b_q;
  logic [RW-1:0]        map_reading;
  logic                 map_done;
  logic [QW-1:0]        mapped;
  logic signed [AW-1:0] ang_a_q, ang_b_q;
  logic                 out_valid_q;
  logic                 out_free;
  logic                 in_xfer;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= dssp_pkg::CFG_RESET;
    end else if (cfg_wr_en_i) begin
      case (dssp_pkg::reg_idx_e'(cfg_addr_i))
        dssp_pkg::REG_MAP_MIN:     cfg_q.map_min     <= cfg_wdata_i;
        dssp_pkg::REG_MAP_MAX:     cfg_q.map_max     <= cfg_wdata_i;
        dssp_pkg::REG_OFFSET_A:    cfg_q.offset_a    <= cfg_wdata_i[OW-1:0];
        dssp_pkg::REG_OFFSET_B:    cfg_q.offset_b    <= cfg_wdata_i[OW-1:0];
        dssp_pkg::REG_MAX_DIFF:    cfg_q.max_diff    <= cfg_wdata_i[dssp_pkg::LIMIT_W-1:0];
        dssp_pkg::REG_DISC_CUTOFF: cfg_q.disc_cutoff <= cfg_wdata_i;
        dssp_pkg::REG_TIMEOUT:     cfg_q.timeout     <= cfg_wdata_i[dssp_pkg::TMO_W-1:0];
        dssp_pkg::REG_SEND_IVL:    cfg_q.send_ivl    <= cfg_wdata_i[dssp_pkg::SEND_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = ctl.in_ready;
  assign in_xfer       = s_axis_tvalid && ctl.in_ready;

  dssp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .map_done_i (map_done),
    .out_free_i (out_free),
    .ctl_o      (ctl)
  );

  // Channel A is mapped straight from the bus in the transfer cycle.
  assign map_reading = ctl.sel_b ? rb_q : (s_axis_tdata[RW-1:0] & READ_MASK);

  dssp_map_unit #(
    .SPAN (ANGLE_SPAN_TENTHS)
  ) u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (ctl.start_map),
    .reading_i (map_reading),
    .map_min_i (cfg_q.map_min),
    .map_max_i (cfg_q.map_max),
    .done_o    (map_done),
    .mapped_o  (mapped)
  );

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ra_q    <= s_axis_tdata[RW-1:0] & READ_MASK;
      rb_q    <= s_axis_tdata[2*RW-1:RW] & READ_MASK;
      raw_a_q <= s_axis_tdata[3*RW-1:2*RW];
      raw_b_q <= s_axis_tdata[4*RW-1:3*RW];
    end
    if (ctl.cap_a) begin
      ang_a_q <= {{(AW - OW){cfg_q.offset_a[OW-1]}}, cfg_q.offset_a}
               - {{(AW - QW){1'b0}}, mapped};
    end
    if (ctl.cap_b) begin
      ang_b_q <= {{(AW - QW){1'b0}}, mapped}
               - {{(AW - OW){cfg_q.offset_b[OW-1]}}, cfg_q.offset_b};
    end
    if (ctl.commit) begin
      out_res_q   <= res;
      out_raw_a_q <= raw_a_q;
      out_raw_b_q <= raw_b_q;
    end
  end

  dssp_monitor #(
    .AW (AW)
  ) u_monitor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .commit_i    (ctl.commit),
    .cfg_i       (cfg_q),
    .reading_a_i (ra_q),
    .reading_b_i (rb_q),
    .ang_a_i     (ang_a_q),
    .ang_b_i     (ang_b_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.commit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(dssp_pkg::OUT_DATA_W - dssp_pkg::OUT_USED_W){1'b0}},
                          out_raw_b_q, out_raw_a_q, out_res_q};

endmodule

`default_nettype wire

/* design/dssp_checker.sv */
// Port-level checker of the steering sensor plausibility block and its bind.
// Uses dssp_pkg and the assertion macros of dual_steering_sensor_plausibility_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "dual_steering_sensor_plausibility_assert.svh"

module dssp_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tvalid_i,
  input wire logic                            s_axis_tready_i,
  input wire logic                            m_axis_tvalid_i,
  input wire logic                            m_axis_tready_i,
  input wire logic [dssp_pkg::OUT_DATA_W-1:0] m_axis_tdata_i
);

  logic dis_seen_q;
  logic warn, dis, imp, disc_any;

  assign warn     = m_axis_tdata_i[dssp_pkg::OUT_WARN_BIT];
  assign dis      = m_axis_tdata_i[dssp_pkg::OUT_DIS_BIT];
  assign imp      = m_axis_tdata_i[dssp_pkg::OUT_IMP_BIT];
  assign disc_any = m_axis_tdata_i[dssp_pkg::OUT_DISC_A_BIT]
                 || m_axis_tdata_i[dssp_pkg::OUT_DISC_B_BIT];

  // Remembers that a report with the disable bit set has gone out.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dis_seen_q <= 1'b0;
    end else if (m_axis_tvalid_i && m_axis_tready_i && dis) begin
      dis_seen_q <= 1'b1;
    end
  end

  `DSSP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_i && !m_axis_tready_i, m_axis_tvalid_i && $stable(m_axis_tdata_i), "stalled report changed")
  `DSSP_ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_i, !s_axis_tready_i, "ready right after a sample transfer")
  `DSSP_ASSERT_SAME(a_warn_flags, clk_i, rst_ni, m_axis_tvalid_i && warn, dis && imp, "warning without disable or implausible")
  `DSSP_ASSERT_SAME(a_disc_imp, clk_i, rst_ni, m_axis_tvalid_i && disc_any, imp, "disconnect not flagged implausible")
  `DSSP_ASSERT_SAME(a_dis_sticky, clk_i, rst_ni, m_axis_tvalid_i && dis_seen_q, dis, "disable latch dropped")

endmodule

bind dual_steering_sensor_plausibility dssp_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid),
  .s_axis_tready_i (s_axis_tready),
  .m_axis_tvalid_i (m_axis_tvalid),
  .m_axis_tready_i (m_axis_tready),
  .m_axis_tdata_i  (m_axis_tdata)
);

`default_nettype wire
